// File: rtl/tpms_pkg.sv
// Package for the typed priority message store: sizes, codes, queue item type.
// No dependencies; imported by every module of the block but tpms_ram.
`default_nettype none
package tpms_pkg;

  localparam int STORE_DEPTH = 16;
  localparam int IDX_W       = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int CNT_W       = $clog2(STORE_DEPTH + 1);
  localparam int HANDLE_W    = 16;
  localparam int ENTRY_W     = HANDLE_W + 4;   // {prio, type, handle}

  localparam int Q_DEPTH     = 2;
  localparam int QPTR_W      = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(Q_DEPTH + 1);

  localparam logic [1:0] TYPE_INVALID = 2'd3;
  localparam logic [1:0] PRIO_INVALID = 2'd0;
  localparam logic       FUNC_INSERT  = 1'b0;

  typedef enum logic [2:0] {
    ST_ACCEPTED  = 3'd0,
    ST_EMPTY_TXT = 3'd1,
    ST_BAD_TYPE  = 3'd2,
    ST_BAD_PRIO  = 3'd3,
    ST_FULL      = 3'd4,
    ST_FOUND     = 3'd5,
    ST_NONE      = 3'd6
  } status_t;

  typedef enum logic [1:0] {
    OP_REJECT = 2'd0,
    OP_INSERT = 2'd1,
    OP_FETCH  = 2'd2
  } op_t;

  typedef struct packed {
    op_t                 op;
    status_t             status;
    logic [1:0]          msg_type;
    logic [1:0]          prio;
    logic [HANDLE_W-1:0] handle;
  } qitem_t;

  typedef struct packed {
    logic             idle;
    logic [CNT_W-1:0] count;
  } bk_stat_t;

endpackage
`default_nettype wire

// File: rtl/tpms_ram.sv
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
`default_nettype none
module tpms_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                         clk,
  input  wire logic                                         we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                             wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                             rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// File: rtl/tpms_front.sv
// Front end: takes requests and runs the insert/fetch field checks.
// Depends on tpms_pkg; feeds the request queue.
`default_nettype none
module tpms_front import tpms_pkg::*; (
  input  wire logic                start,
  input  wire logic                q_full,
  input  wire logic                in_func,
  input  wire logic [1:0]          in_msg_type,
  input  wire logic [1:0]          in_priority_req,
  input  wire logic                in_text_empty,
  input  wire logic [HANDLE_W-1:0] in_message_handle,
  output logic                     push,
  output qitem_t                   item
);
  assign push = start && !q_full;

  always_comb begin
    item.op       = OP_REJECT;
    item.status   = ST_ACCEPTED;
    item.msg_type = in_msg_type;
    item.prio     = in_priority_req;
    item.handle   = in_message_handle;
    if (in_func == FUNC_INSERT) begin
      // check order: empty text, type, priority; full is checked at the store
      if (in_text_empty) begin
        item.status = ST_EMPTY_TXT;
      end else if (in_msg_type == TYPE_INVALID) begin
        item.status = ST_BAD_TYPE;
      end else if (in_priority_req == PRIO_INVALID) begin
        item.status = ST_BAD_PRIO;
      end else begin
        item.op = OP_INSERT;
      end
    end else begin
      if (in_msg_type == TYPE_INVALID) begin
        item.status = ST_BAD_TYPE;
      end else begin
        item.op = OP_FETCH;
      end
    end
  end
endmodule
`default_nettype wire

// File: rtl/tpms_fifo.sv
// Short request queue between the front end and the store engine.
// Depends on tpms_pkg.
`default_nettype none
module tpms_fifo import tpms_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire logic   push,
  input  wire qitem_t din,
  input  wire logic   pop,
  output qitem_t      dout,
  output logic        empty,
  output logic        full
);
  qitem_t              slot_r [Q_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0]   cnt_r, cnt_nxt;
  logic                do_push, do_pop;

  assign empty   = (cnt_r == '0);
  assign full    = (cnt_r == QCNT_W'(Q_DEPTH));
  assign dout    = slot_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + QPTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + QPTR_W'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + QCNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= din;
    end
  end
endmodule
`default_nettype wire

// File: rtl/tpms_back.sv
// Store engine: appends inserts, scans and compacts the entry RAM on fetch,
// and drives the result strobe. Depends on tpms_pkg and tpms_ram.
`default_nettype none
module tpms_back import tpms_pkg::*; (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                q_empty,
  input  wire qitem_t              q_item,
  output logic                     q_pop,
  output logic                     out_valid,
  output logic [2:0]               out_status,
  output logic [HANDLE_W-1:0]      out_found_handle,
  output bk_stat_t                 stat
);
  typedef enum logic [2:0] {
    B_IDLE  = 3'b001,
    B_SCAN  = 3'b010,
    B_SHIFT = 3'b100
  } bstate_t;

  bstate_t             state_r, state_nxt;
  logic [CNT_W-1:0]    count_r, count_nxt;
  logic [CNT_W-1:0]    idx_r, idx_nxt;          // next RAM read index
  logic [CNT_W-1:0]    chk_idx_r, chk_idx_nxt;  // index of data now on rdata
  logic                chk_vld_r, chk_vld_nxt;
  logic [1:0]          f_type_r, f_type_nxt;
  logic                have_r, have_nxt;
  logic [CNT_W-1:0]    best_idx_r, best_idx_nxt;
  logic [1:0]          best_prio_r, best_prio_nxt;
  logic [HANDLE_W-1:0] best_hdl_r, best_hdl_nxt;
  logic                ovld_r, ovld_nxt;
  status_t             ost_r, ost_nxt;
  logic [HANDLE_W-1:0] ohdl_r, ohdl_nxt;

  logic                ram_we;
  logic [IDX_W-1:0]    ram_waddr, ram_raddr;
  logic [ENTRY_W-1:0]  ram_wdata, ram_rdata;
  logic [CNT_W-1:0]    shift_dst;
  logic                issue;

  tpms_ram #(.WIDTH(ENTRY_W), .DEPTH(STORE_DEPTH)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign issue     = (idx_r < count_r);
  assign shift_dst = chk_idx_r - CNT_W'(1);
  assign ram_raddr = idx_r[IDX_W-1:0];
  assign q_pop     = (state_r == B_IDLE) && !q_empty;

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    idx_nxt       = idx_r;
    chk_idx_nxt   = chk_idx_r;
    chk_vld_nxt   = 1'b0;
    f_type_nxt    = f_type_r;
    have_nxt      = have_r;
    best_idx_nxt  = best_idx_r;
    best_prio_nxt = best_prio_r;
    best_hdl_nxt  = best_hdl_r;
    ovld_nxt      = 1'b0;
    ost_nxt       = ost_r;
    ohdl_nxt      = ohdl_r;
    ram_we        = 1'b0;
    ram_waddr     = count_r[IDX_W-1:0];
    ram_wdata     = {q_item.prio, q_item.msg_type, q_item.handle};

    case (state_r)
      B_IDLE: begin
        if (!q_empty) begin
          case (q_item.op)
            OP_INSERT: begin
              ovld_nxt = 1'b1;
              ohdl_nxt = '0;
              if (count_r >= CNT_W'(STORE_DEPTH)) begin
                ost_nxt = ST_FULL;
              end else begin
                ram_we    = 1'b1;
                count_nxt = count_r + CNT_W'(1);
                ost_nxt   = ST_ACCEPTED;
              end
            end
            OP_FETCH: begin
              f_type_nxt = q_item.msg_type;
              have_nxt   = 1'b0;
              idx_nxt    = '0;
              state_nxt  = B_SCAN;
            end
            default: begin
              ovld_nxt = 1'b1;
              ost_nxt  = q_item.status;
              ohdl_nxt = '0;
            end
          endcase
        end
      end

      B_SCAN: begin
        if (issue) begin
          idx_nxt     = idx_r + CNT_W'(1);
          chk_vld_nxt = 1'b1;
          chk_idx_nxt = idx_r;
        end
        // strict greater-than keeps the earliest entry on ties
        if (chk_vld_r && ram_rdata[HANDLE_W+1:HANDLE_W] == f_type_r &&
            (!have_r || ram_rdata[HANDLE_W+3:HANDLE_W+2] > best_prio_r)) begin
          have_nxt      = 1'b1;
          best_idx_nxt  = chk_idx_r;
          best_prio_nxt = ram_rdata[HANDLE_W+3:HANDLE_W+2];
          best_hdl_nxt  = ram_rdata[HANDLE_W-1:0];
        end
        if (!issue && !chk_vld_r) begin
          if (!have_r) begin
            ovld_nxt  = 1'b1;
            ost_nxt   = ST_NONE;
            ohdl_nxt  = '0;
            state_nxt = B_IDLE;
          end else begin
            idx_nxt   = best_idx_r + CNT_W'(1);
            state_nxt = B_SHIFT;
          end
        end
      end

      B_SHIFT: begin
        if (issue) begin
          idx_nxt     = idx_r + CNT_W'(1);
          chk_vld_nxt = 1'b1;
          chk_idx_nxt = idx_r;
        end
        // move entry i down to i-1 while entry i+1 is being read
        if (chk_vld_r) begin
          ram_we    = 1'b1;
          ram_waddr = shift_dst[IDX_W-1:0];
          ram_wdata = ram_rdata;
        end
        if (!issue && !chk_vld_r) begin
          count_nxt = count_r - CNT_W'(1);
          ovld_nxt  = 1'b1;
          ost_nxt   = ST_FOUND;
          ohdl_nxt  = best_hdl_r;
          state_nxt = B_IDLE;
        end
      end

      default: begin
        state_nxt = B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= B_IDLE;
      count_r   <= '0;
      chk_vld_r <= 1'b0;
      ovld_r    <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      count_r   <= count_nxt;
      chk_vld_r <= chk_vld_nxt;
      ovld_r    <= ovld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r       <= idx_nxt;
    chk_idx_r   <= chk_idx_nxt;
    f_type_r    <= f_type_nxt;
    have_r      <= have_nxt;
    best_idx_r  <= best_idx_nxt;
    best_prio_r <= best_prio_nxt;
    best_hdl_r  <= best_hdl_nxt;
    ost_r       <= ost_nxt;
    ohdl_r      <= ohdl_nxt;
  end

  assign out_valid        = ovld_r;
  assign out_status       = ost_r;
  assign out_found_handle = ohdl_r;
  assign stat.idle        = (state_r == B_IDLE);
  assign stat.count       = count_r;
endmodule
`default_nettype wire

// File: rtl/typed_priority_message_store_unit.sv
// Top level of the typed priority message store: front end, request queue,
// store engine. Depends on tpms_pkg, tpms_front, tpms_fifo, tpms_back.
`default_nettype none
// A request is taken when start is high and busy is low; busy rises only
// when the two-deep request queue is full. Each request yields exactly one
// result, shown for one cycle with out_valid; results leave in request order
// and the receiver cannot hold them off. Rejected requests and inserts are
// settled as the idle store engine pops them from the queue, and their result
// is registered in the engine. A fetch scans the entry RAM one entry per
// cycle through its single read port, then shifts the entries after the
// removed one down by one; the engine pops no new request until the fetch
// has produced its result.
module typed_priority_message_store_unit import tpms_pkg::*; (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  output logic                     busy,
  input  wire logic                in_func,
  input  wire logic [1:0]          in_msg_type,
  input  wire logic [1:0]          in_priority_req,
  input  wire logic                in_text_empty,
  input  wire logic [HANDLE_W-1:0] in_message_handle,
  output logic                     out_valid,
  output logic [2:0]               out_status,
  output logic [HANDLE_W-1:0]      out_found_handle
);
  logic     q_push, q_pop, q_empty, q_full;
  qitem_t   q_din, q_dout;
  bk_stat_t bk_stat;

  assign busy = q_full;

  tpms_front u_front (
    .start             (start),
    .q_full            (q_full),
    .in_func           (in_func),
    .in_msg_type       (in_msg_type),
    .in_priority_req   (in_priority_req),
    .in_text_empty     (in_text_empty),
    .in_message_handle (in_message_handle),
    .push              (q_push),
    .item              (q_din)
  );

  tpms_fifo u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .din   (q_din),
    .pop   (q_pop),
    .dout  (q_dout),
    .empty (q_empty),
    .full  (q_full)
  );

  tpms_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_empty          (q_empty),
    .q_item           (q_dout),
    .q_pop            (q_pop),
    .out_valid        (out_valid),
    .out_status       (out_status),
    .out_found_handle (out_found_handle),
    .stat             (bk_stat)
  );

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    bk_stat.count <= CNT_W'(STORE_DEPTH))
    else $error("entry count above store depth");

  a_handle_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_FOUND |-> out_found_handle == '0)
    else $error("nonzero handle on a result other than found");

  a_count_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !bk_stat.idle && $past(!bk_stat.idle) |-> bk_stat.count == $past(bk_stat.count))
    else $error("entry count changed in the middle of a fetch");

  a_found_has_entry: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_FOUND |-> bk_stat.count < CNT_W'(STORE_DEPTH))
    else $error("found result without a removed entry");
endmodule
`default_nettype wire

// File: sim/tpms_check_pkg.sv
`timescale 1ns / 100ps
// Scoreboard for the typed priority message store: a behavioral copy of the
// store that predicts each result, plus the in-order check of actual results.
// Depends on tpms_pkg.
package tpms_check_pkg;
  import tpms_pkg::*;

  localparam logic       FUNC_FETCH  = 1'b1;
  localparam logic [1:0] TYPE_RED    = 2'd0;
  localparam logic [1:0] TYPE_YELLOW = 2'd1;
  localparam logic [1:0] TYPE_BLUE   = 2'd2;
  localparam logic [1:0] PRIO_LOW    = 2'd1;
  localparam logic [1:0] PRIO_MID    = 2'd2;
  localparam logic [1:0] PRIO_HIGH   = 2'd3;

  typedef struct {
    logic [HANDLE_W-1:0] handle;
    logic [1:0]          kind;
    logic [1:0]          prio;
  } stored_msg_t;

  typedef struct {
    status_t             status;
    logic [HANDLE_W-1:0] handle;
  } outcome_t;

  class msg_store_scoreboard;
    stored_msg_t held_msgs[$];         // arrival order, oldest first
    outcome_t    pending_outcomes[$];
    int errors;
    int requests;
    int results;
    int found_count;
    int full_count;

    function outcome_t predict_outcome(logic func, logic [1:0] kind, logic [1:0] prio,
                                       logic empty, logic [HANDLE_W-1:0] handle);
      outcome_t    res;
      stored_msg_t msg;
      int          best;
      res.handle = '0;
      best       = -1;
      if (func == FUNC_INSERT) begin
        // checks in order: text, type, priority, capacity
        if (empty)
          res.status = ST_EMPTY_TXT;
        else if (kind == TYPE_INVALID)
          res.status = ST_BAD_TYPE;
        else if (prio == PRIO_INVALID)
          res.status = ST_BAD_PRIO;
        else if (held_msgs.size() >= STORE_DEPTH)
          res.status = ST_FULL;
        else begin
          msg.handle = handle;
          msg.kind   = kind;
          msg.prio   = prio;
          held_msgs.insert(held_msgs.size(), msg);
          res.status = ST_ACCEPTED;
        end
      end else if (kind == TYPE_INVALID) begin
        res.status = ST_BAD_TYPE;
      end else begin
        // strict greater keeps the earliest entry on a tie
        foreach (held_msgs[i])
          if (held_msgs[i].kind == kind &&
              (best < 0 || held_msgs[i].prio > held_msgs[best].prio))
            best = i;
        if (best < 0)
          res.status = ST_NONE;
        else begin
          res.status = ST_FOUND;
          res.handle = held_msgs[best].handle;
          held_msgs.delete(best);
        end
      end
      return res;
    endfunction

    function void note_request(logic func, logic [1:0] kind, logic [1:0] prio,
                               logic empty, logic [HANDLE_W-1:0] handle);
      outcome_t res;
      res = predict_outcome(func, kind, prio, empty, handle);
      requests++;
      if (res.status == ST_FOUND) found_count++;
      if (res.status == ST_FULL) full_count++;
      pending_outcomes.insert(pending_outcomes.size(), res);
    endfunction

    function void check_result(logic [2:0] status, logic [HANDLE_W-1:0] handle);
      outcome_t exp;
      if (pending_outcomes.size() == 0) begin
        $error("result with no request outstanding: status %0d found_handle %h",
               status, handle);
        errors++;
        return;
      end
      exp = pending_outcomes.pop_front();
      results++;
      if (status !== exp.status) begin
        $error("status: expected %0d, actual %0d", exp.status, status);
        errors++;
      end
      if (handle !== exp.handle) begin
        $error("found_handle: expected %h, actual %h", exp.handle, handle);
        errors++;
      end
    endfunction

    function int outstanding();
      return pending_outcomes.size();
    endfunction
  endclass

endpackage

// File: sim/tb_top.sv
`timescale 1ns / 100ps
// Testbench top for typed_priority_message_store_unit: directed and random
// requests under varying sender gaps. Depends on tpms_pkg and tpms_check_pkg.
module tb_top;
  import tpms_pkg::*;
  import tpms_check_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 80;

  logic                clk;
  logic                rst_n;
  logic                start;
  logic                busy;
  logic                in_func;
  logic [1:0]          in_msg_type;
  logic [1:0]          in_priority_req;
  logic                in_text_empty;
  logic [HANDLE_W-1:0] in_message_handle;
  logic                out_valid;
  logic [2:0]          out_status;
  logic [HANDLE_W-1:0] out_found_handle;

  msg_store_scoreboard sb = new;
  int cycle_count = 0;

  typed_priority_message_store_unit dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_func           (in_func),
    .in_msg_type       (in_msg_type),
    .in_priority_req   (in_priority_req),
    .in_text_empty     (in_text_empty),
    .in_message_handle (in_message_handle),
    .out_valid         (out_valid),
    .out_status        (out_status),
    .out_found_handle  (out_found_handle)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // values read here are the ones the block saw at this edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (start && !busy)
        sb.note_request(in_func, in_msg_type, in_priority_req, in_text_empty,
                        in_message_handle);
      if (out_valid)
        sb.check_result(out_status, out_found_handle);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $error("timeout after %0d cycles, %0d results outstanding", cycle_count,
             sb.outstanding());
      $display("tb_top: FAIL");
      $finish;
    end
  end

  // optional random gap, then hold the request until it is taken
  task automatic issue(input logic func, input logic [1:0] kind, input logic [1:0] prio,
                       input logic empty, input logic [HANDLE_W-1:0] handle,
                       input int idle_pct);
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
    start             <= 1'b1;
    in_func           <= func;
    in_msg_type       <= kind;
    in_priority_req   <= prio;
    in_text_empty     <= empty;
    in_message_handle <= handle;
    do @(posedge clk); while (busy);
  endtask

  // mostly well-formed inserts and fetches; the insert share swings so the
  // store fills up and drains; a tenth is unconstrained noise
  task automatic run_random(input int n_items, input int idle_pct);
    int insert_pct;
    int pick;
    insert_pct = 70;
    for (int i = 0; i < n_items; i++) begin
      if (i % 40 == 0)
        insert_pct = ($urandom_range(1) != 0) ? 75 : 30;
      pick = $urandom_range(99);
      if (pick < 10)
        issue(1'($urandom_range(1)), 2'($urandom_range(3)), 2'($urandom_range(3)),
              1'($urandom_range(1)), HANDLE_W'($urandom_range(65535)), idle_pct);
      else if (pick - 10 < insert_pct * 90 / 100)
        issue(FUNC_INSERT, 2'($urandom_range(2)), 2'($urandom_range(3, 1)), 1'b0,
              HANDLE_W'($urandom_range(65535)), idle_pct);
      else
        issue(FUNC_FETCH, 2'($urandom_range(2)), 2'($urandom_range(3)),
              1'($urandom_range(1)), HANDLE_W'($urandom_range(65535)), idle_pct);
    end
  endtask

  initial begin
    start             <= 1'b0;
    in_func           <= FUNC_INSERT;
    in_msg_type       <= TYPE_RED;
    in_priority_req   <= PRIO_INVALID;
    in_text_empty     <= 1'b0;
    in_message_handle <= '0;
    rst_n             <= 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty store: nothing to fetch, then a fetch of the invalid type
    issue(FUNC_FETCH, TYPE_RED, PRIO_HIGH, 1'b0, 16'h0000, 30);
    issue(FUNC_FETCH, TYPE_YELLOW, PRIO_LOW, 1'b1, 16'h1234, 30);
    issue(FUNC_FETCH, TYPE_BLUE, PRIO_MID, 1'b0, 16'hFFFF, 30);
    issue(FUNC_FETCH, TYPE_INVALID, PRIO_HIGH, 1'b1, 16'hFFFF, 30);
    // rejected inserts: empty text wins over type, type over priority
    issue(FUNC_INSERT, TYPE_INVALID, PRIO_INVALID, 1'b1, 16'hFFFF, 30);
    issue(FUNC_INSERT, TYPE_INVALID, PRIO_INVALID, 1'b0, 16'hA5A5, 30);
    issue(FUNC_INSERT, TYPE_BLUE, PRIO_INVALID, 1'b0, 16'h5A5A, 30);
    // fill the store with ties across types, then overflow it
    for (int i = 0; i < STORE_DEPTH; i++)
      issue(FUNC_INSERT, 2'(i % 3), 2'(1 + (i / 3) % 3), 1'b0,
            (i == 0) ? 16'h0000 : (i == 1) ? 16'hFFFF : HANDLE_W'($urandom_range(65535)),
            30);
    issue(FUNC_INSERT, TYPE_YELLOW, PRIO_HIGH, 1'b0, 16'h0F0F, 30);
    issue(FUNC_FETCH, TYPE_RED, PRIO_INVALID, 1'b0, 16'h0000, 30);

    run_random(340, 30);
    run_random(340, 65);
    run_random(320, 0);
    start <= 1'b0;

    while (sb.outstanding() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("tb_top: %0d requests and %0d results checked in %0d cycles",
             sb.requests, sb.results, cycle_count);
    $display("tb_top: %0d fetches removed an entry, %0d inserts met a full store",
             sb.found_count, sb.full_count);
    if (sb.errors == 0 && sb.outstanding() == 0)
      $display("tb_top: PASS");
    else
      $display("tb_top: FAIL");
    $finish;
  end

endmodule
